// ===== hdl/lru_key_value_cache_macros.svh =====
// Assertion macros for the LRU key/value cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lkv_pkg.sv =====
// Package: sizes, payload types and entry array types for the LRU key/value cache.
`default_nettype none

package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 5;
	localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);
	localparam int EFF_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic {
		FUNC_GET = 1'b0,
		FUNC_PUT = 1'b1
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

	typedef logic [DATA_W-1:0] word_arr_t [ENTRIES];
	typedef logic [RANK_W-1:0] rank_arr_t [ENTRIES];

	// Result of the parallel compare over all entries.
	typedef struct packed {
		logic [ENTRIES-1:0] hit_oh;
		logic [ENTRIES-1:0] free_oh;
		logic [ENTRIES-1:0] victim_oh;
		logic [RANK_W-1:0]  hit_rank;
		logic [DATA_W-1:0]  read_data;
		logic [DATA_W-1:0]  victim_key;
	} look_t;

endpackage

`default_nettype wire

// ===== hdl/lkv_lookup.sv =====
// Parallel key compare, free-slot search and victim select over all entries.
`default_nettype none

module lkv_lookup (
	input  wire logic [lkv_pkg::DATA_W-1:0]  key,
	input  wire lkv_pkg::word_arr_t          key_arr,
	input  wire lkv_pkg::word_arr_t          value_arr,
	input  wire logic [lkv_pkg::ENTRIES-1:0] valid,
	input  wire lkv_pkg::rank_arr_t          rank_arr,
	input  wire logic [lkv_pkg::OCC_W-1:0]   occ,
	output lkv_pkg::look_t                   look
);
	import lkv_pkg::*;

	logic [OCC_W-1:0] occ_m1;

	// Valid entries hold ranks 0 .. occ-1, so the oldest is the one at occ-1.
	assign occ_m1 = occ - OCC_W'(1);

	always_comb begin
		look.hit_oh     = '0;
		look.victim_oh  = '0;
		look.hit_rank   = '0;
		look.read_data  = '0;
		look.victim_key = '0;
		// lowest clear bit of the valid vector
		look.free_oh    = ~valid & (valid + ENTRIES'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			look.hit_oh[i]    = valid[i] && (key_arr[i] == key);
			look.victim_oh[i] = valid[i] && (rank_arr[i] == occ_m1[RANK_W-1:0]);
		end
		// keys are unique among valid entries, so AND-OR selects one entry
		for (int i = 0; i < ENTRIES; i++) begin
			look.hit_rank   = look.hit_rank   | (rank_arr[i]  & {RANK_W{look.hit_oh[i]}});
			look.read_data  = look.read_data  | (value_arr[i] & {DATA_W{look.hit_oh[i]}});
			look.victim_key = look.victim_key | (key_arr[i]   & {DATA_W{look.victim_oh[i]}});
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lkv_entries.sv =====
// Entry state (keys, values, valid bits, age ranks, occupancy) and its update per transaction.
`default_nettype none

module lkv_entries (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	input  wire lkv_pkg::req_t               req,
	input  wire logic [lkv_pkg::CAP_W-1:0]   capacity,
	output lkv_pkg::rsp_t                    rsp,
	output logic [lkv_pkg::OCC_W-1:0]        occ
);
	import lkv_pkg::*;

	word_arr_t          key_q;
	word_arr_t          value_q;
	logic [ENTRIES-1:0] valid_q;
	rank_arr_t          rank_q;
	logic [OCC_W-1:0]   occ_q;

	look_t              look;
	logic               hit;
	logic               is_put;
	logic [EFF_W-1:0]   eff_cap;
	logic               room;
	logic               do_fill;
	logic               do_evict;
	logic               touch;
	logic               age_all;
	logic [RANK_W-1:0]  age_limit;
	logic [OCC_W-1:0]   occ_m1;
	logic [ENTRIES-1:0] sel_oh;

	lkv_lookup u_lookup (
		.key       (req.key),
		.key_arr   (key_q),
		.value_arr (value_q),
		.valid     (valid_q),
		.rank_arr  (rank_q),
		.occ       (occ_q),
		.look      (look)
	);

	assign occ    = occ_q;
	assign occ_m1 = occ_q - OCC_W'(1);

	always_comb begin
		hit    = |look.hit_oh;
		is_put = (req.func == FUNC_PUT);
		// zero means one, anything above the built depth saturates
		if (capacity == '0) begin
			eff_cap = EFF_W'(1);
		end else if (EFF_W'(capacity) > EFF_W'(ENTRIES)) begin
			eff_cap = EFF_W'(ENTRIES);
		end else begin
			eff_cap = EFF_W'(capacity);
		end
		room      = EFF_W'(occ_q) < eff_cap;
		do_fill   = item_valid && is_put && !hit && room;
		do_evict  = item_valid && is_put && !hit && !room;
		touch     = (item_valid && hit) || do_fill || do_evict;
		age_all   = do_fill;
		age_limit = hit ? look.hit_rank : occ_m1[RANK_W-1:0];
		if (hit) begin
			sel_oh = look.hit_oh;
		end else if (do_fill) begin
			sel_oh = look.free_oh;
		end else begin
			sel_oh = look.victim_oh;
		end

		rsp.hit         = hit;
		rsp.evicted     = do_evict;
		rsp.evicted_key = do_evict ? look.victim_key : '0;
		if (is_put) begin
			rsp.read_value = '0;
		end else if (hit) begin
			rsp.read_value = look.read_data;
		end else begin
			rsp.read_value = '1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && is_put) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (sel_oh[i] && (hit || do_fill || do_evict)) begin
					value_q[i] <= req.value;
					key_q[i]   <= req.key;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (do_fill) begin
				valid_q <= valid_q | look.free_oh;
				occ_q   <= occ_q + OCC_W'(1);
			end
			if (touch) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (sel_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (age_all || rank_q[i] < age_limit)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Top level: fully associative key/value cache with least-recently-used replacement.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  request   start / busy (always 0)   req : func, key, value
//  result    rsp_valid strobe          rsp : hit, read_value, evicted, evicted_key
//  config    cfg_valid / cfg_ready     cfg_data : capacity
//
// A transaction is taken every cycle; busy never rises. The acceptance edge loads
// the input register; the next edge takes the parallel compare and rank update
// into the result register and entry state and raises the strobe, so the strobe
// and the result register change together.
// Reset clears valid bits, ranks, occupancy and sets capacity to 16.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module lru_key_value_cache (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire lkv_pkg::req_t             req,
	output logic                           rsp_valid,
	output lkv_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [lkv_pkg::CAP_W-1:0] cfg_data
);
	import lkv_pkg::*;

	`include "lru_key_value_cache_macros.svh"

	logic             start_s1;
	req_t             req_s1;
	logic             rsp_valid_s2;
	rsp_t             rsp_s2;
	logic [CAP_W-1:0] capacity_q;
	rsp_t             rsp_next;
	logic [OCC_W-1:0] occ;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			capacity_q   <= CAP_RESET;
		end else begin
			start_s1     <= start && !busy;
			rsp_valid_s2 <= start_s1;
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (start_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	lkv_entries u_entries (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (start_s1),
		.req        (req_s1),
		.capacity   (capacity_q),
		.rsp        (rsp_next),
		.occ        (occ)
	);

	`LKV_ASSERT_NEXT(a_rsp_follows, start_s1, rsp_valid, "accepted transaction gave no result")
	`LKV_ASSERT_NOW(a_evict_miss, rsp_valid && rsp.evicted, !rsp.hit, "eviction on a hit")
	`LKV_ASSERT_NOW(a_evict_occ, rsp_valid && rsp.evicted, $stable(occ), "eviction changed occupancy")
	`LKV_ASSERT_NOW(a_occ_range, 1'b1, occ <= OCC_W'(ENTRIES), "occupancy above depth")

endmodule

`default_nettype wire
